[rtl/core/b64b32_pkg.sv]
// Package for the base64/base32 codec: sequencer states, register indexes, alphabet tables.
`default_nettype none

package b64b32_pkg;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_RUN,
    ST_FIN
  } seq_state_t;

  typedef enum logic {
    REG_ALPHABET_MODE = 1'b0,
    REG_DIRECTION     = 1'b1
  } cfg_reg_t;

  localparam logic [7:0] PAD_CHAR = 8'h3D;

  // group value to alphabet character; mode 1 is base32
  function automatic logic [7:0] enc_char(input logic mode, input logic [5:0] v);
    logic [7:0] c;
    logic [7:0] v8;
    v8 = {2'b00, v};
    if (mode) begin
      if (v[4:0] < 5'd26) begin
        c = 8'h41 + {3'b000, v[4:0]};
      end else begin
        c = 8'h32 + {3'b000, v[4:0]} - 8'd26;
      end
    end else begin
      if (v8 < 8'd26) begin
        c = 8'h41 + v8;
      end else if (v8 < 8'd52) begin
        c = 8'h61 + v8 - 8'd26;
      end else if (v8 < 8'd62) begin
        c = 8'h30 + v8 - 8'd52;
      end else if (v8 == 8'd62) begin
        c = 8'h2B;
      end else begin
        c = 8'h2F;
      end
    end
    return c;
  endfunction

  // lenient text byte to group value: {hit, value}
  function automatic logic [6:0] dec_map(input logic mode, input logic [7:0] c);
    logic [6:0] r;
    r = 7'd0;
    if (mode) begin
      if (c inside {[8'h41:8'h5A]}) begin
        r = {1'b1, 6'(c - 8'h41)};
      end else if (c inside {[8'h61:8'h7A]}) begin
        r = {1'b1, 6'(c - 8'h61)};
      end else if (c inside {[8'h32:8'h37]}) begin
        r = {1'b1, 6'(c - 8'h32 + 8'd26)};
      end else if (c == 8'h30) begin
        r = {1'b1, 6'd14};
      end else if (c == 8'h31) begin
        r = {1'b1, 6'd11};
      end else if (c == 8'h39) begin
        r = {1'b1, 6'd6};
      end
    end else begin
      if (c inside {[8'h41:8'h5A]}) begin
        r = {1'b1, 6'(c - 8'h41)};
      end else if (c inside {[8'h61:8'h7A]}) begin
        r = {1'b1, 6'(c - 8'h61 + 8'd26)};
      end else if (c inside {[8'h30:8'h39]}) begin
        r = {1'b1, 6'(c - 8'h30 + 8'd52)};
      end else if (c inside {8'h2B, 8'h2D}) begin
        r = {1'b1, 6'd62};
      end else if (c inside {8'h2F, 8'h5F}) begin
        r = {1'b1, 6'd63};
      end
    end
    return r;
  endfunction

endpackage

`default_nettype wire

[rtl/core/base64_base32_codec.sv]
// Streaming base64/base32 encoder and decoder, one byte per input transfer.
//
// Each input transfer is loaded, then its results are taken one at a time through a
// single shared extract unit (a barrel shift of the bit accumulator plus a group mask),
// then the sequencer finds that no further result is due and closes the item. In a
// steady stream, encoding a byte gives one or two characters; the last byte of a
// message adds the flush character and '=' padding, at most 8 results. Decoding
// gives at most one byte per character. in_stall is high from the cycle after a
// transfer until the item is closed. Results pass through a pending register and an
// output register, so a stall on the output holds the sequencer only when a second
// result is ready or the item closes with a result or end marker to send. A last
// text byte that yields no data byte gives one end marker (out_empty).
// Configuration must be written only while idle; the block does not enforce this.
`default_nettype none

module base64_base32_codec
  import b64b32_pkg::*;
(
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic       cfg_write,
  input  wire logic       cfg_index,
  input  wire logic       cfg_data,
  input  wire logic       in_valid,
  output logic            in_stall,
  input  wire logic [7:0] in_byte,
  input  wire logic       in_last,
  output logic            out_valid,
  input  wire logic       out_stall,
  output logic [7:0]      out_byte,
  output logic            out_last,
  output logic            out_empty
);

  seq_state_t  state, state_next;
  logic        alphabet_mode, direction;
  logic [12:0] acc, acc_next;
  logic [3:0]  bit_count, bit_count_next;
  logic [2:0]  char_phase, char_phase_next;
  logic [20:0] wacc, wacc_next;
  logic [4:0]  wbits, wbits_next;
  logic [2:0]  phase, phase_next;
  logic [3:0]  cnt, cnt_next;
  logic        wlast, wlast_next;
  logic [7:0]  pend, pend_next;
  logic        pend_valid, pend_valid_next;

  logic        out_free, out_load;
  logic [7:0]  load_byte;
  logic        load_last, load_empty;

  logic [4:0]  grp;
  logic [4:0]  fw;
  logic [4:0]  sh_amt;
  logic [25:0] shifted;
  logic [7:0]  field;
  logic [6:0]  dm;
  logic        pad_due, produce, done;
  logic [7:0]  res;
  logic [4:0]  wbits_step;
  logic        need_out;

  assign grp      = alphabet_mode ? 5'd5 : 5'd6;
  assign fw       = direction ? 5'd8 : grp;
  // shared extract unit
  assign sh_amt   = wbits + 5'd5 - fw;
  assign shifted  = {wacc, 5'b00000} >> sh_amt;
  assign field    = shifted[7:0] & (direction ? 8'hFF : (alphabet_mode ? 8'h1F : 8'h3F));
  assign dm       = dec_map(alphabet_mode, in_byte);
  assign pad_due  = alphabet_mode ? (phase != 3'd0) : (phase[1:0] != 2'd0);
  assign out_free = !out_valid || !out_stall;
  assign in_stall = (state != ST_IDLE);
  assign need_out = pend_valid || (wlast && direction);

  always_comb begin
    produce    = 1'b0;
    done       = 1'b0;
    res        = 8'd0;
    wbits_step = wbits;
    if (!direction) begin
      if (wbits >= grp && cnt < 4'd8) begin
        produce    = 1'b1;
        res        = enc_char(alphabet_mode, field[5:0]);
        wbits_step = wbits - grp;
      end else if (wlast && wbits != 5'd0 && cnt < 4'd8) begin
        produce    = 1'b1;
        res        = enc_char(alphabet_mode, field[5:0]);
        wbits_step = 5'd0;
      end else if (wlast && pad_due && cnt < 4'd8) begin
        produce    = 1'b1;
        res        = PAD_CHAR;
      end else begin
        done       = 1'b1;
      end
    end else begin
      if (wbits >= 5'd8 && cnt < 4'd8) begin
        produce    = 1'b1;
        res        = field;
        wbits_step = wbits - 5'd8;
      end else begin
        done       = 1'b1;
      end
    end
  end

  always_comb begin
    state_next      = state;
    acc_next        = acc;
    bit_count_next  = bit_count;
    char_phase_next = char_phase;
    wacc_next       = wacc;
    wbits_next      = wbits;
    phase_next      = phase;
    cnt_next        = cnt;
    wlast_next      = wlast;
    pend_next       = pend;
    pend_valid_next = pend_valid;
    out_load        = 1'b0;
    load_byte       = pend;
    load_last       = 1'b0;
    load_empty      = 1'b0;
    case (state)
      ST_IDLE: begin
        if (in_valid) begin
          wlast_next      = in_last;
          phase_next      = char_phase;
          cnt_next        = 4'd0;
          pend_valid_next = 1'b0;
          if (!direction) begin
            wacc_next  = {acc, in_byte};
            wbits_next = {1'b0, bit_count} + 5'd8;
          end else if (dm[6]) begin
            wacc_next  = alphabet_mode ? {3'b000, acc, dm[4:0]} : {2'b00, acc, dm[5:0]};
            wbits_next = {1'b0, bit_count} + grp;
          end else begin
            wacc_next  = {8'd0, acc};
            wbits_next = {1'b0, bit_count};
          end
          state_next = ST_RUN;
        end
      end
      ST_RUN: begin
        if (produce) begin
          if (!pend_valid || out_free) begin
            out_load        = pend_valid;
            pend_next       = res;
            pend_valid_next = 1'b1;
            wbits_next      = wbits_step;
            cnt_next        = cnt + 4'd1;
            if (!direction) begin
              phase_next = phase + 3'd1;
            end
          end
        end else if (done) begin
          state_next = ST_FIN;
        end
      end
      ST_FIN: begin
        if (!need_out || out_free) begin
          out_load        = need_out;
          load_byte       = pend_valid ? pend : 8'd0;
          load_last       = wlast;
          load_empty      = !pend_valid;
          pend_valid_next = 1'b0;
          if (wlast) begin
            acc_next        = 13'd0;
            bit_count_next  = 4'd0;
            char_phase_next = 3'd0;
          end else begin
            acc_next        = wacc[12:0];
            bit_count_next  = wbits[3:0];
            char_phase_next = phase;
          end
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= ST_IDLE;
      alphabet_mode <= 1'b0;
      direction     <= 1'b0;
      acc           <= 13'd0;
      bit_count     <= 4'd0;
      char_phase    <= 3'd0;
      cnt           <= 4'd0;
      pend_valid    <= 1'b0;
      out_valid     <= 1'b0;
    end else begin
      state      <= state_next;
      acc        <= acc_next;
      bit_count  <= bit_count_next;
      char_phase <= char_phase_next;
      cnt        <= cnt_next;
      pend_valid <= pend_valid_next;
      if (cfg_write) begin
        if (cfg_index == REG_ALPHABET_MODE) begin
          alphabet_mode <= cfg_data;
        end else begin
          direction <= cfg_data;
        end
      end
      if (out_load) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    wacc  <= wacc_next;
    wbits <= wbits_next;
    phase <= phase_next;
    wlast <= wlast_next;
    pend  <= pend_next;
    if (out_load) begin
      out_byte  <= load_byte;
      out_last  <= load_last;
      out_empty <= load_empty;
    end
  end

  a_cnt_bound: assert property (@(posedge clk) disable iff (rst)
    cnt <= 4'd8)
    else $error("result count above eight");

  a_pend_busy: assert property (@(posedge clk) disable iff (rst)
    pend_valid |-> state != ST_IDLE)
    else $error("pending result left while idle");

  a_empty_marker: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_empty) |-> (out_last && out_byte == 8'd0))
    else $error("end marker malformed");

  a_last_clears: assert property (@(posedge clk) disable iff (rst)
    (state == ST_FIN && state_next == ST_IDLE && wlast) |=>
      (acc == 13'd0 && bit_count == 4'd0 && char_phase == 3'd0))
    else $error("message end did not clear state");

  a_load_free: assert property (@(posedge clk) disable iff (rst)
    out_load |-> out_free)
    else $error("output register overwritten");

endmodule

`default_nettype wire
